// ===== src/betweenness_centrality_engine_macros.svh =====
// assertion macros for the betweenness centrality engine
// used by files that assert; expects clk and rst_n in scope
`ifndef BETWEENNESS_CENTRALITY_ENGINE_MACROS_SVH
`define BETWEENNESS_CENTRALITY_ENGINE_MACROS_SVH

// expression must never hold outside reset
`define BCE_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// same-cycle implication
`define BCE_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BCE_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bce_pkg.sv =====
// shared types, constants and saturating add for the centrality engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

    localparam int HOP_W = 7;
    localparam int CNT_W = 32;
    localparam logic [HOP_W-1:0] UNVISITED = '1;
    localparam logic [CNT_W-1:0] SAT32 = '1;

    typedef struct packed {
        logic [HOP_W-1:0] hop;
        logic [CNT_W-1:0] path;
        logic [CNT_W-1:0] dep;
    } node_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic [5:0] src;
        logic [5:0] dst;
    } edge_cmd_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? SAT32 : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/betweenness_centrality_engine.sv =====
// betweenness centrality engine top: edge loading, breadth-first passes, result output
// depends on bce_pkg, bce_edge_store, bce_divider, betweenness_centrality_engine_macros.svh
//
// input channel (in_valid / in_stall) carries one word per directed edge, sources in
// non-decreasing order; a word with edge_valid low is an empty marker. edge words are
// taken while in_stall is low. a word with last_edge high loads its edge and then
// starts the computation; in_stall stays high until the last result word has been taken.
// the computation makes one breadth-first pass per source over node_count nodes (0 is
// taken as 1, values above MAX_NODES as MAX_NODES), walking node, order and centrality
// memories: the centrality memory is cleared first, then each pass clears the node
// memory, walks reached nodes and their edges forward, then walks them backward in
// reverse order, calling the bit-serial dependency divider for each successor edge.
// then one result word per node, in node order, on the output channel (out_valid /
// out_stall); each word is read only once the one before is taken; a stalled word holds.
// after the last result the edge store is emptied for the next graph; node_count is kept.
// cfg_we writes node_count from cfg_data; the user sets it only while the block is idle;
// the block does not enforce it. reset empties the edge store and sets node_count to 64.
`timescale 1ns / 1ps
`default_nettype none
`include "betweenness_centrality_engine_macros.svh"

module betweenness_centrality_engine
    import bce_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024,
    parameter int FRAC_BITS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  source_node,
    input  wire logic [5:0]  target_node,
    input  wire logic        edge_valid,
    input  wire logic        last_edge,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [5:0]  node_index,
    output logic      [31:0] centrality,
    output logic             edges_dropped,
    output logic             last_result
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EFW = $clog2(MAX_EDGES + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CCLR   = 5'd1;
    localparam logic [4:0] S_P_CLR  = 5'd2;
    localparam logic [4:0] S_F_POP  = 5'd3;
    localparam logic [4:0] S_F_V    = 5'd4;
    localparam logic [4:0] S_F_ROW  = 5'd5;
    localparam logic [4:0] S_F_EDGE = 5'd6;
    localparam logic [4:0] S_F_W    = 5'd7;
    localparam logic [4:0] S_F_UPD  = 5'd8;
    localparam logic [4:0] S_B_POP  = 5'd9;
    localparam logic [4:0] S_B_W    = 5'd10;
    localparam logic [4:0] S_B_ROW  = 5'd11;
    localparam logic [4:0] S_B_EDGE = 5'd12;
    localparam logic [4:0] S_B_X    = 5'd13;
    localparam logic [4:0] S_B_XD   = 5'd14;
    localparam logic [4:0] S_B_DIV  = 5'd15;
    localparam logic [4:0] S_B_FIN  = 5'd16;
    localparam logic [4:0] S_B_CENT = 5'd17;
    localparam logic [4:0] S_O_RD   = 5'd18;
    localparam logic [4:0] S_O_LD   = 5'd19;
    localparam logic [4:0] S_O_WAIT = 5'd20;

    logic [4:0]       state_reg, state_next;
    logic [6:0]       node_count_reg, node_count_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [NW-1:0]    src_reg, src_next;
    logic [NW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    head_reg, head_next;
    logic [NW-1:0]    tail_reg, tail_next;
    logic [IW-1:0]    a_reg, a_next;
    logic [IW-1:0]    b_reg, b_next;
    logic [EFW-1:0]   e_reg, e_next;
    logic [EFW-1:0]   rend_reg, rend_next;
    logic [HOP_W-1:0] hop_reg, hop_next;
    logic [CNT_W-1:0] path_reg, path_next;
    logic [CNT_W-1:0] dacc_reg, dacc_next;
    logic             out_valid_reg, out_valid_next;
    logic [5:0]       out_idx_reg;
    logic [CNT_W-1:0] out_cent_reg;
    logic             out_drop_reg;
    logic             out_last_reg;

    node_t            node_mem [MAX_NODES];
    logic [IW-1:0]    order_mem [MAX_NODES];
    logic [CNT_W-1:0] cent_mem [MAX_NODES];
    node_t            node_rd_reg;
    logic [IW-1:0]    order_rd_reg;
    logic [CNT_W-1:0] cent_rd_reg;

    logic             node_we, order_we, cent_we;
    logic [IW-1:0]    node_waddr, node_raddr, order_waddr, order_raddr;
    logic [IW-1:0]    cent_waddr, cent_raddr;
    node_t            node_wdata;
    logic [IW-1:0]    order_wdata;
    logic [CNT_W-1:0] cent_wdata;
    logic             out_load;

    edge_cmd_t      cmd;
    logic [IW-1:0]  row_raddr;
    logic [EFW-1:0] row_start, row_end;
    logic [EAW-1:0] adj_raddr;
    logic [5:0]     adj_rdata;
    logic           dropped;

    logic             div_start, div_done;
    logic [CNT_W-1:0] div_quot;

    logic             in_acc, out_acc;
    logic [HOP_W-1:0] hop_inc;
    logic             adj_in_range;
    logic             enq;
    logic [HOP_W-1:0] upd_hop;
    logic [NW-1:0]    n_eff;

    assign in_acc       = in_valid && !in_stall;
    assign out_acc      = out_valid_reg && !out_stall;
    assign hop_inc      = hop_reg + HOP_W'(1);
    assign adj_in_range = {1'b0, adj_rdata} < 7'(n_reg);
    assign enq          = (node_rd_reg.hop == UNVISITED) && (head_reg < NW'(MAX_NODES));
    assign upd_hop      = enq ? hop_inc : node_rd_reg.hop;
    assign n_eff        = (node_count_reg == '0) ? NW'(1) :
                          (node_count_reg > 7'(MAX_NODES)) ? NW'(MAX_NODES) :
                          NW'(node_count_reg);

    bce_edge_store #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .row_raddr (row_raddr),
        .row_start (row_start),
        .row_end   (row_end),
        .adj_raddr (adj_raddr),
        .adj_rdata (adj_rdata),
        .dropped   (dropped)
    );

    bce_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (path_reg),
        .den   (node_rd_reg.path),
        .dep   (node_rd_reg.dep),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = cfg_we ? cfg_data : node_count_reg;
        n_next          = n_reg;
        src_next        = src_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        e_next          = e_reg;
        rend_next       = rend_reg;
        hop_next        = hop_reg;
        path_next       = path_reg;
        dacc_next       = dacc_reg;
        out_valid_next  = out_valid_reg;
        out_load        = 1'b0;
        node_we         = 1'b0;
        node_waddr      = a_reg;
        node_wdata      = '{hop: hop_reg, path: path_reg, dep: dacc_reg};
        node_raddr      = a_reg;
        order_we        = 1'b0;
        order_waddr     = head_reg[IW-1:0];
        order_wdata     = b_reg;
        order_raddr     = tail_reg[IW-1:0];
        cent_we         = 1'b0;
        cent_waddr      = a_reg;
        cent_wdata      = sat_add(cent_rd_reg, dacc_reg);
        cent_raddr      = a_reg;
        row_raddr       = order_rd_reg;
        adj_raddr       = e_reg[EAW-1:0];
        div_start       = 1'b0;
        cmd.load        = in_acc && edge_valid;
        cmd.clear       = 1'b0;
        cmd.src         = source_node;
        cmd.dst         = target_node;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && last_edge)
                begin
                    n_next     = n_eff;
                    idx_next   = '0;
                    state_next = S_CCLR;
                end
            end
            S_CCLR:
            begin
                cent_we    = 1'b1;
                cent_waddr = idx_reg[IW-1:0];
                cent_wdata = '0;
                idx_next   = idx_reg + NW'(1);
                if (idx_reg == n_reg - NW'(1))
                begin
                    idx_next   = '0;
                    src_next   = '0;
                    state_next = S_P_CLR;
                end
            end
            S_P_CLR:
            begin
                node_we    = 1'b1;
                node_waddr = idx_reg[IW-1:0];
                node_wdata = (idx_reg == src_reg) ?
                             node_t'{hop: '0, path: CNT_W'(1), dep: '0} :
                             node_t'{hop: UNVISITED, path: '0, dep: '0};
                order_we    = idx_reg == '0;
                order_waddr = '0;
                order_wdata = src_reg[IW-1:0];
                idx_next    = idx_reg + NW'(1);
                if (idx_reg == n_reg - NW'(1))
                begin
                    head_next  = NW'(1);
                    tail_next  = '0;
                    state_next = S_F_POP;
                end
            end
            S_F_POP:
            begin
                if (tail_reg == head_reg || tail_reg >= NW'(MAX_NODES))
                begin
                    idx_next   = head_reg;
                    state_next = S_B_POP;
                end
                else
                begin
                    tail_next  = tail_reg + NW'(1);
                    state_next = S_F_V;
                end
            end
            S_F_V:
            begin
                a_next     = order_rd_reg;
                node_raddr = order_rd_reg;
                state_next = S_F_ROW;
            end
            S_F_ROW:
            begin
                e_next     = row_start;
                rend_next  = row_end;
                hop_next   = node_rd_reg.hop;
                path_next  = node_rd_reg.path;
                state_next = S_F_EDGE;
            end
            S_F_EDGE:
            begin
                if (e_reg >= rend_reg)
                begin
                    state_next = S_F_POP;
                end
                else
                begin
                    e_next     = e_reg + EFW'(1);
                    state_next = S_F_W;
                end
            end
            S_F_W:
            begin
                node_raddr = adj_rdata[IW-1:0];
                b_next     = adj_rdata[IW-1:0];
                state_next = adj_in_range ? S_F_UPD : S_F_EDGE;
            end
            S_F_UPD:
            begin
                order_we   = enq;
                head_next  = enq ? head_reg + NW'(1) : head_reg;
                node_we    = 1'b1;
                node_waddr = b_reg;
                node_wdata = '{hop: upd_hop,
                               path: (upd_hop == hop_inc) ?
                                     sat_add(node_rd_reg.path, path_reg) : node_rd_reg.path,
                               dep: node_rd_reg.dep};
                state_next = S_F_EDGE;
            end
            S_B_POP:
            begin
                order_raddr = IW'(idx_reg - NW'(1));
                if (idx_reg == '0)
                begin
                    src_next = src_reg + NW'(1);
                    idx_next = '0;
                    state_next = (src_reg == n_reg - NW'(1)) ? S_O_RD : S_P_CLR;
                end
                else
                begin
                    idx_next   = idx_reg - NW'(1);
                    state_next = S_B_W;
                end
            end
            S_B_W:
            begin
                a_next     = order_rd_reg;
                node_raddr = order_rd_reg;
                state_next = S_B_ROW;
            end
            S_B_ROW:
            begin
                e_next     = row_start;
                rend_next  = row_end;
                hop_next   = node_rd_reg.hop;
                path_next  = node_rd_reg.path;
                dacc_next  = node_rd_reg.dep;
                state_next = S_B_EDGE;
            end
            S_B_EDGE:
            begin
                if (e_reg >= rend_reg)
                begin
                    state_next = S_B_FIN;
                end
                else
                begin
                    e_next     = e_reg + EFW'(1);
                    state_next = S_B_X;
                end
            end
            S_B_X:
            begin
                node_raddr = adj_rdata[IW-1:0];
                state_next = adj_in_range ? S_B_XD : S_B_EDGE;
            end
            S_B_XD:
            begin
                if (node_rd_reg.hop == hop_inc)
                begin
                    div_start  = 1'b1;
                    state_next = S_B_DIV;
                end
                else
                begin
                    state_next = S_B_EDGE;
                end
            end
            S_B_DIV:
            begin
                if (div_done)
                begin
                    dacc_next  = sat_add(dacc_reg, div_quot);
                    state_next = S_B_EDGE;
                end
            end
            S_B_FIN:
            begin
                node_we    = 1'b1;
                state_next = (a_reg != src_reg[IW-1:0]) ? S_B_CENT : S_B_POP;
            end
            S_B_CENT:
            begin
                cent_we    = 1'b1;
                state_next = S_B_POP;
            end
            S_O_RD:
            begin
                cent_raddr = idx_reg[IW-1:0];
                state_next = S_O_LD;
            end
            S_O_LD:
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_O_WAIT;
            end
            S_O_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + NW'(1);
                        state_next = S_O_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 7'd64;
            n_reg          <= NW'(MAX_NODES);
            src_reg        <= '0;
            idx_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            n_reg          <= n_next;
            src_reg        <= src_next;
            idx_reg        <= idx_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        rend_reg <= rend_next;
        hop_reg  <= hop_next;
        path_reg <= path_next;
        dacc_reg <= dacc_next;
        if (out_load)
        begin
            out_idx_reg  <= 6'(idx_reg);
            out_cent_reg <= cent_rd_reg;
            out_drop_reg <= dropped;
            out_last_reg <= idx_reg == n_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rd_reg <= node_mem[node_raddr];
        if (order_we)
            order_mem[order_waddr] <= order_wdata;
        order_rd_reg <= order_mem[order_raddr];
        if (cent_we)
            cent_mem[cent_waddr] <= cent_wdata;
        cent_rd_reg <= cent_mem[cent_raddr];
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign node_index    = out_idx_reg;
    assign centrality    = out_cent_reg;
    assign edges_dropped = out_drop_reg;
    assign last_result   = out_last_reg;

    `BCE_NEVER(a_head_range, head_reg > NW'(MAX_NODES), "queue head beyond node limit")
    `BCE_NEVER(a_tail_head, tail_reg > head_reg, "queue tail passed head")
    `BCE_IMPLY(a_out_state, out_valid_reg, state_reg == S_O_WAIT, "result word outside wait")
    `BCE_NEXT(a_div_hold, state_reg == S_B_DIV && !div_done, state_reg == S_B_DIV, "divide left")

endmodule

`default_nettype wire

// ===== src/bce_edge_store.sv =====
// edge store: adjacency target memory and per-source row bounds
// depends on bce_pkg
`timescale 1ns / 1ps
`default_nettype none

module bce_edge_store
    import bce_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024,
    localparam int IW  = $clog2(MAX_NODES),
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int EFW = $clog2(MAX_EDGES + 1)
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire edge_cmd_t       cmd,
    input  wire logic [IW-1:0]   row_raddr,
    output logic      [EFW-1:0]  row_start,
    output logic      [EFW-1:0]  row_end,
    input  wire logic [EAW-1:0]  adj_raddr,
    output logic      [5:0]      adj_rdata,
    output logic                 dropped
);

    logic [5:0]       adj_mem [MAX_EDGES];
    logic [2*EFW-1:0] row_mem [MAX_NODES];

    logic [EFW-1:0]       fill_reg, fill_next;
    logic [EFW-1:0]       cur_start_reg, cur_start_next;
    logic [5:0]           last_reg, last_next;
    logic                 dropped_reg, dropped_next;
    logic [MAX_NODES-1:0] valid_reg, valid_next;

    logic [5:0]       adj_rd_reg;
    logic [2*EFW-1:0] row_rd_reg;
    logic             row_vld_reg;

    logic           drop;
    logic           take;
    logic [IW-1:0]  src_idx;
    logic [EFW-1:0] start_val;

    assign src_idx   = cmd.src[IW-1:0];
    assign drop      = ({1'b0, cmd.src} >= 7'(MAX_NODES)) || (cmd.src < last_reg)
                       || (fill_reg == EFW'(MAX_EDGES));
    assign take      = cmd.load && !drop;
    assign start_val = valid_reg[src_idx] ? cur_start_reg : fill_reg;

    always_comb
    begin
        fill_next      = fill_reg;
        cur_start_next = cur_start_reg;
        last_next      = last_reg;
        dropped_next   = dropped_reg;
        valid_next     = valid_reg;
        if (cmd.clear)
        begin
            fill_next    = '0;
            last_next    = '0;
            dropped_next = 1'b0;
            valid_next   = '0;
        end
        else if (cmd.load)
        begin
            if (drop)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                fill_next           = fill_reg + EFW'(1);
                cur_start_next      = start_val;
                last_next           = cmd.src;
                valid_next[src_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            cur_start_reg <= '0;
            last_reg      <= '0;
            dropped_reg   <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            cur_start_reg <= cur_start_next;
            last_reg      <= last_next;
            dropped_reg   <= dropped_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            adj_mem[fill_reg[EAW-1:0]] <= cmd.dst;
            row_mem[src_idx]           <= {start_val, fill_reg + EFW'(1)};
        end
        adj_rd_reg  <= adj_mem[adj_raddr];
        row_rd_reg  <= row_mem[row_raddr];
        row_vld_reg <= valid_reg[row_raddr];
    end

    assign row_start = row_vld_reg ? row_rd_reg[2*EFW-1:EFW] : '0;
    assign row_end   = row_vld_reg ? row_rd_reg[EFW-1:0] : '0;
    assign adj_rdata = adj_rd_reg;
    assign dropped   = dropped_reg;

endmodule

`default_nettype wire

// ===== src/bce_divider.sv =====
// dependency term unit: floor(num * (1.0 + dep) / den), saturated, bit-serial divide
// depends on bce_pkg
`timescale 1ns / 1ps
`default_nettype none

module bce_divider
    import bce_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] num,
    input  wire logic [CNT_W-1:0] den,
    input  wire logic [CNT_W-1:0] dep,
    output logic                  done,
    output logic      [CNT_W-1:0] quot
);

    localparam int PW = 2 * CNT_W + 1;
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_ADD  = 3'd2;
    localparam logic [2:0] PH_ITER = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]         phase_reg, phase_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]   num_reg, den_reg, dep_reg;
    logic [2*CNT_W-1:0] prod_reg;
    logic [PW-1:0]      p_reg;
    logic [CNT_W-1:0]   rem_reg;

    logic [CNT_W:0] trial;
    logic           ge;

    assign trial = {rem_reg, p_reg[PW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_MUL;
            PH_MUL:  phase_next = PH_ADD;
            PH_ADD:
            begin
                phase_next = PH_ITER;
                cnt_next   = '0;
            end
            PH_ITER:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(PW - 1)) phase_next = PH_DONE;
            end
            PH_DONE: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            num_reg <= num;
            den_reg <= den;
            dep_reg <= dep;
        end
        if (phase_reg == PH_MUL)
            prod_reg <= num_reg * dep_reg;
        if (phase_reg == PH_ADD)
        begin
            p_reg   <= {1'b0, prod_reg} + (PW'(num_reg) << FRAC_BITS);
            rem_reg <= '0;
        end
        if (phase_reg == PH_ITER)
        begin
            p_reg   <= {p_reg[PW-2:0], ge};
            rem_reg <= ge ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
        end
    end

    assign done = phase_reg == PH_DONE;
    assign quot = (den_reg == '0) ? '0 :
                  (|p_reg[PW-1:CNT_W]) ? SAT32 : p_reg[CNT_W-1:0];

endmodule

`default_nettype wire
